// ===== rtl/sbws_pkg.sv =====
// Shared types and constants for the SPI bus word sniffer.
package sbws_pkg;

  // Default parameter values
  localparam int MAX_WORDS_DEF   = 256;
  localparam int SAMPLE_BITS_DEF = 48;

  // Field widths
  localparam int SAMPLE_W    = 48;
  localparam int WORD_W      = 64;
  localparam int WBITS_W     = 7;
  localparam int COUNT_W     = 9;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 248;

  // Default word size, also used when the configured size is out of range
  localparam logic [WBITS_W-1:0] WORD_BITS_DEF = 7'd8;
  localparam logic [WBITS_W-1:0] WORD_BITS_MAX = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CPOL        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPHA        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LSB_FIRST   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_ACT_HI  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MISO_PRES   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOSI_PRES   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SEL_PRES    = 4'd7;

  // Event kinds
  localparam logic EV_INITIAL = 1'b0;

  // Result kinds
  localparam logic [1:0] RES_SELECT = 2'd0;
  localparam logic [1:0] RES_WORD   = 2'd1;
  localparam logic [1:0] RES_END    = 2'd2;

  // Previous select level when it is not known
  localparam logic [1:0] CS_UNKNOWN = 2'd2;

  typedef struct packed {
    logic                clock_polarity;
    logic                clock_phase;
    logic                lsb_first;
    logic                select_active_high;
    logic [WBITS_W-1:0]  word_bits;
    logic                miso_present;
    logic                mosi_present;
    logic                select_present;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample_index;
    logic                clk_level;
    logic                miso_level;
    logic                mosi_level;
    logic                cs_level;
    logic                clk_edge;
    logic                cs_edge;
  } event_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic                last;
    logic [1:0]          cs_old;
    logic                cs_new;
    logic [WORD_W-1:0]   mosi_word;
    logic [WORD_W-1:0]   miso_word;
    logic [SAMPLE_W-1:0] first_sample;
    logic [SAMPLE_W-1:0] end_sample;
    logic [COUNT_W-1:0]  mosi_count;
    logic [COUNT_W-1:0]  miso_count;
  } result_t;

endpackage

// ===== rtl/sbws_core.sv =====
// Decode logic and protocol state: turns one registered pin event into up to two results.
module sbws_core #(
  parameter int MAX_WORDS   = sbws_pkg::MAX_WORDS_DEF,
  parameter int SAMPLE_BITS = sbws_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sbws_pkg::event_t  ev,
  input  sbws_pkg::cfg_t    cfg,
  output sbws_pkg::result_t res0,
  output sbws_pkg::result_t res1,
  output logic [1:0]        n_res
);

  localparam int SW = (SAMPLE_BITS < sbws_pkg::SAMPLE_W) ? SAMPLE_BITS : sbws_pkg::SAMPLE_W;
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WORDS);

  // Protocol state
  logic [sbws_pkg::WBITS_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [sbws_pkg::WORD_W-1:0]  mosi_sh_r, mosi_sh_nxt;
  logic [sbws_pkg::WORD_W-1:0]  miso_sh_r, miso_sh_nxt;
  logic [SW-1:0]                word_start_r, word_start_nxt;
  logic                         skip_r, skip_nxt;
  logic                         topen_r, topen_nxt;
  logic [SW-1:0]                tbegin_r, tbegin_nxt;
  logic [CW-1:0]                mosi_seen_r, mosi_seen_nxt;
  logic [CW-1:0]                miso_seen_r, miso_seen_nxt;

  logic [SW-1:0]                sample;
  logic [sbws_pkg::WBITS_W-1:0] size;
  logic                         asserted;
  logic                         active;
  logic                         cs_ev;
  logic                         do_open;
  logic                         do_end;
  logic                         do_bit;
  logic                         do_word;
  logic [sbws_pkg::WBITS_W-1:0] bc_cur;
  logic [sbws_pkg::WBITS_W-1:0] bc_inc;
  logic [sbws_pkg::WORD_W-1:0]  mosi_cur;
  logic [sbws_pkg::WORD_W-1:0]  miso_cur;
  logic [sbws_pkg::WORD_W-1:0]  mosi_new;
  logic [sbws_pkg::WORD_W-1:0]  miso_new;
  logic [SW-1:0]                wstart_new;
  logic [CW-1:0]                mosi_base;
  logic [CW-1:0]                miso_base;
  sbws_pkg::result_t            r_sel;
  sbws_pkg::result_t            r_end;
  sbws_pkg::result_t            r_word;

  // Event decode
  always_comb begin
    sample   = ev.sample_index[SW-1:0];
    size     = (cfg.word_bits != '0 && cfg.word_bits <= sbws_pkg::WORD_BITS_MAX) ?
               cfg.word_bits : sbws_pkg::WORD_BITS_DEF;
    asserted = cfg.select_active_high ? ev.cs_level : ~ev.cs_level;
    active   = cfg.select_present ? asserted : 1'b1;
    cs_ev    = (ev.kind != sbws_pkg::EV_INITIAL) && cfg.select_present && ev.cs_edge;
    if (ev.kind == sbws_pkg::EV_INITIAL) begin
      do_open = cfg.select_present && asserted;
    end else begin
      do_open = cs_ev && active;
    end
    do_end = cs_ev && !active && topen_r;
  end

  // Bit sampling on the configured clock edge; a select edge first clears the partial word
  always_comb begin
    bc_cur   = cs_ev ? '0 : bit_cnt_r;
    mosi_cur = cs_ev ? '0 : mosi_sh_r;
    miso_cur = cs_ev ? '0 : miso_sh_r;
    do_bit   = (ev.kind != sbws_pkg::EV_INITIAL) && active && ev.clk_edge && !skip_r &&
               (ev.clk_level == (cfg.clock_polarity == cfg.clock_phase));
    bc_inc   = bc_cur + 7'd1;
    do_word  = do_bit && (bc_inc == size);
    wstart_new = (bc_cur == '0) ? sample : word_start_r;

    mosi_new = mosi_cur;
    miso_new = miso_cur;
    if (cfg.mosi_present) begin
      if (!cfg.lsb_first) begin
        mosi_new = {mosi_cur[sbws_pkg::WORD_W-2:0], ev.mosi_level};
      end else if (!bc_cur[6]) begin
        mosi_new = mosi_cur | (sbws_pkg::WORD_W'(ev.mosi_level) << bc_cur[5:0]);
      end
    end
    if (cfg.miso_present) begin
      if (!cfg.lsb_first) begin
        miso_new = {miso_cur[sbws_pkg::WORD_W-2:0], ev.miso_level};
      end else if (!bc_cur[6]) begin
        miso_new = miso_cur | (sbws_pkg::WORD_W'(ev.miso_level) << bc_cur[5:0]);
      end
    end
  end

  // Result candidates
  always_comb begin
    r_sel = '0;
    r_sel.result_kind = sbws_pkg::RES_SELECT;
    if (ev.kind == sbws_pkg::EV_INITIAL) begin
      r_sel.cs_old = sbws_pkg::CS_UNKNOWN;
      r_sel.cs_new = cfg.select_present ? ev.cs_level : 1'b1;
    end else begin
      r_sel.cs_old = {1'b0, ~ev.cs_level};
      r_sel.cs_new = ev.cs_level;
    end

    r_end = '0;
    r_end.result_kind  = sbws_pkg::RES_END;
    r_end.first_sample = sbws_pkg::SAMPLE_W'(tbegin_r);
    r_end.end_sample   = sbws_pkg::SAMPLE_W'(sample);
    r_end.mosi_count   = cfg.mosi_present ? sbws_pkg::COUNT_W'(mosi_seen_r) : '0;
    r_end.miso_count   = cfg.miso_present ? sbws_pkg::COUNT_W'(miso_seen_r) : '0;

    r_word = '0;
    r_word.result_kind  = sbws_pkg::RES_WORD;
    r_word.mosi_word    = cfg.mosi_present ? mosi_new : '0;
    r_word.miso_word    = cfg.miso_present ? miso_new : '0;
    r_word.first_sample = sbws_pkg::SAMPLE_W'(wstart_new);
    r_word.end_sample   = sbws_pkg::SAMPLE_W'(sample);
  end

  // Order the results: select change, then transfer end or data word
  always_comb begin
    if (ev.kind == sbws_pkg::EV_INITIAL) begin
      n_res = 2'd1;
      res0  = r_sel;
      res1  = r_sel;
    end else begin
      n_res = 2'(cs_ev) + 2'(do_end) + 2'(do_word);
      res0  = cs_ev ? r_sel : r_word;
      res1  = do_end ? r_end : r_word;
    end
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // Next state
  always_comb begin
    mosi_base = do_open ? '0 : mosi_seen_r;
    miso_base = do_open ? '0 : miso_seen_r;

    topen_nxt  = topen_r | do_open;
    tbegin_nxt = do_open ? sample : tbegin_r;
    mosi_seen_nxt = mosi_base;
    miso_seen_nxt = miso_base;
    skip_nxt       = skip_r;
    word_start_nxt = word_start_r;
    bit_cnt_nxt    = bit_cnt_r;
    mosi_sh_nxt    = mosi_sh_r;
    miso_sh_nxt    = miso_sh_r;

    if (ev.kind != sbws_pkg::EV_INITIAL) begin
      bit_cnt_nxt = bc_cur;
      mosi_sh_nxt = mosi_cur;
      miso_sh_nxt = miso_cur;
      if (active && ev.clk_edge) begin
        skip_nxt = 1'b0;
      end
      if (do_bit) begin
        word_start_nxt = wstart_new;
        bit_cnt_nxt    = bc_inc;
        mosi_sh_nxt    = mosi_new;
        miso_sh_nxt    = miso_new;
      end
      if (do_word) begin
        bit_cnt_nxt = '0;
        mosi_sh_nxt = '0;
        miso_sh_nxt = '0;
        if (cfg.mosi_present && mosi_base < CNT_MAX) begin
          mosi_seen_nxt = mosi_base + CW'(1);
        end
        if (cfg.miso_present && miso_base < CNT_MAX) begin
          miso_seen_nxt = miso_base + CW'(1);
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_cnt_r    <= '0;
      mosi_sh_r    <= '0;
      miso_sh_r    <= '0;
      word_start_r <= '0;
      skip_r       <= 1'b1;
      topen_r      <= 1'b0;
      tbegin_r     <= '0;
      mosi_seen_r  <= '0;
      miso_seen_r  <= '0;
    end else if (fire) begin
      bit_cnt_r    <= bit_cnt_nxt;
      mosi_sh_r    <= mosi_sh_nxt;
      miso_sh_r    <= miso_sh_nxt;
      word_start_r <= word_start_nxt;
      skip_r       <= skip_nxt;
      topen_r      <= topen_nxt;
      tbegin_r     <= tbegin_nxt;
      mosi_seen_r  <= mosi_seen_nxt;
      miso_seen_r  <= miso_seen_nxt;
    end
  end

endmodule

// ===== rtl/sbws_out.sv =====
// Two-slot result stage: an output register plus one slot for a second result of the same event.
module sbws_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [1:0]        n_res,
  input  sbws_pkg::result_t res0,
  input  sbws_pkg::result_t res1,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output sbws_pkg::result_t out_res
);

  logic              out_valid_r, out_valid_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  sbws_pkg::result_t out_r, out_nxt;
  sbws_pkg::result_t pend_r, pend_nxt;

  // Room for a whole event's results once the current output transaction completes
  assign slot_free = !pend_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    if (out_valid_r && out_ready) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (push && n_res != 2'd0) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = res0;
      pend_valid_nxt = (n_res == 2'd2);
      pend_nxt       = res1;
    end
  end

  // Valid flags take reset; the payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== rtl/spi_bus_word_sniffer_unit.sv =====
// Top level of the SPI bus word sniffer: input register, configuration registers and stages.
//
// Passive SPI decoder fed with pin events from a logic capture stream. Each event is held in an
// input register, decoded against the protocol state in one pass and its results written to a
// two-slot output stage. An event that yields no result or one result leaves the input register
// at once, so one event per clock is sustained while out_tready stays high; an event that yields
// two results (a select change followed by a transfer end or a data word) holds back the next
// event until both have left through the single output register. Configuration is written
// through the cfg_ port, which is always ready, and must only be changed while idle.
module spi_bus_word_sniffer_unit #(
  parameter int MAX_WORDS   = sbws_pkg::MAX_WORDS_DEF,
  parameter int SAMPLE_BITS = sbws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input events
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sample_index[47:0], clk_level[48], miso_level[49], mosi_level[50], cs_level[51],
  // clk_edge[52], cs_edge[53], zero[55:54]
  input  logic [sbws_pkg::IN_TDATA_W-1:0]     in_tdata,
  // kind[0]
  input  logic                                in_tuser,
  // Results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cs_old[1:0], cs_new[2], mosi_word[66:3], miso_word[130:67], first_sample[178:131],
  // end_sample[226:179], mosi_count[235:227], miso_count[244:236], zero[247:245]
  output logic [sbws_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // result_kind[1:0]
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic              in_valid_r;
  sbws_pkg::event_t  ev_r;
  sbws_pkg::cfg_t    cfg_r;
  logic              fire;
  logic              slot_free;
  logic [1:0]        n_res;
  sbws_pkg::result_t res0;
  sbws_pkg::result_t res1;
  sbws_pkg::result_t out_res;

  // An event is processed once the output stage can take all of its results
  assign fire      = in_valid_r && (slot_free || n_res == 2'd0);
  assign in_tready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ev_r.kind         <= in_tuser;
      ev_r.sample_index <= in_tdata[47:0];
      ev_r.clk_level    <= in_tdata[48];
      ev_r.miso_level   <= in_tdata[49];
      ev_r.mosi_level   <= in_tdata[50];
      ev_r.cs_level     <= in_tdata[51];
      ev_r.clk_edge     <= in_tdata[52];
      ev_r.cs_edge      <= in_tdata[53];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_polarity     <= 1'b0;
      cfg_r.clock_phase        <= 1'b0;
      cfg_r.lsb_first          <= 1'b0;
      cfg_r.select_active_high <= 1'b0;
      cfg_r.word_bits          <= sbws_pkg::WORD_BITS_DEF;
      cfg_r.miso_present       <= 1'b1;
      cfg_r.mosi_present       <= 1'b1;
      cfg_r.select_present     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbws_pkg::REG_CPOL:       cfg_r.clock_polarity     <= cfg_data[0];
        sbws_pkg::REG_CPHA:       cfg_r.clock_phase        <= cfg_data[0];
        sbws_pkg::REG_LSB_FIRST:  cfg_r.lsb_first          <= cfg_data[0];
        sbws_pkg::REG_SEL_ACT_HI: cfg_r.select_active_high <= cfg_data[0];
        sbws_pkg::REG_WORD_BITS:  cfg_r.word_bits          <= cfg_data;
        sbws_pkg::REG_MISO_PRES:  cfg_r.miso_present       <= cfg_data[0];
        sbws_pkg::REG_MOSI_PRES:  cfg_r.mosi_present       <= cfg_data[0];
        sbws_pkg::REG_SEL_PRES:   cfg_r.select_present     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sbws_core #(
    .MAX_WORDS   (MAX_WORDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ev    (ev_r),
    .cfg   (cfg_r),
    .res0  (res0),
    .res1  (res1),
    .n_res (n_res)
  );

  sbws_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Result packing
  assign out_tuser = out_res.result_kind;
  assign out_tlast = out_res.last;
  assign out_tdata = {3'b000, out_res.miso_count, out_res.mosi_count, out_res.end_sample,
                      out_res.first_sample, out_res.miso_word, out_res.mosi_word,
                      out_res.cs_new, out_res.cs_old};

endmodule

// ===== sim/tb_spi_bus_word_sniffer_unit.sv =====
// Self-checking testbench for the SPI bus word sniffer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_spi_bus_word_sniffer_unit;

  localparam logic EV_EDGE      = ~sbws_pkg::EV_INITIAL;
  localparam int   LIMIT_CYCLES = 200000;
  localparam int   SETTLE       = 8;
  localparam int   LONG_HOLD    = 300;
  localparam int   SAT_EDGES    = 280;

  typedef struct {
    sbws_pkg::event_t  ev;
    bit                typed;
    sbws_pkg::result_t want;
  } stim_row_t;

  typedef struct {
    sbws_pkg::cfg_t c;
    int   send_idle;
    int   recv_stall;
    int   n_items;
    bit   saturate;
    bit   pressure;
  } phase_plan_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [sbws_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [sbws_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                       out_tuser;
  logic                             out_tlast;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [sbws_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [sbws_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Expectation typed into the directed table travels alongside its transaction
  logic              row_typed = 1'b0;
  sbws_pkg::result_t row_want  = '0;

  // Expected results still to leave the block
  sbws_pkg::result_t pending_results[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      cycles     = 0;

  // Idling controls
  int send_idle  = 0;
  int stall_pct  = 0;
  bit hold_req   = 1'b0;
  bit hold_used  = 1'b0;
  int hold_left  = 0;

  // Pin state seen by the stimulus generator, and the settings it believes are loaded
  sbws_pkg::cfg_t                cur_cfg;
  logic [sbws_pkg::SAMPLE_W-1:0] cap_sample = '0;
  logic                          pin_clk    = 1'b0;
  logic                          pin_cs     = 1'b1;

  // Mirror of the configuration and of the decoder state
  sbws_pkg::cfg_t                mirror_cfg;
  logic [6:0]                    p_bit_cnt;
  logic [sbws_pkg::WORD_W-1:0]   p_mosi_sh;
  logic [sbws_pkg::WORD_W-1:0]   p_miso_sh;
  logic [sbws_pkg::SAMPLE_W-1:0] p_word_first;
  logic                          p_skip_edge;
  logic                          p_xfer_open;
  logic [sbws_pkg::SAMPLE_W-1:0] p_xfer_start;
  logic [sbws_pkg::COUNT_W-1:0]  p_mosi_seen;
  logic [sbws_pkg::COUNT_W-1:0]  p_miso_seen;

  stim_row_t   dir_rows[$];
  phase_plan_t plans[12];

  spi_bus_word_sniffer_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_spi_bus_word_sniffer_unit NOT OK");
      $finish;
    end
  end

  // Word size actually used by the decoder; out-of-range settings fall back to the default.
  function automatic logic [6:0] eff_size(input logic [6:0] wb);
    return (wb >= 7'd1 && wb <= sbws_pkg::WORD_BITS_MAX) ? wb : sbws_pkg::WORD_BITS_DEF;
  endfunction

  // Word counters stop at the maximum.
  function automatic logic [sbws_pkg::COUNT_W-1:0] bump_count(
      input logic [sbws_pkg::COUNT_W-1:0] c);
    return (c < sbws_pkg::COUNT_W'(sbws_pkg::MAX_WORDS_DEF)) ?
           c + 1'b1 : sbws_pkg::COUNT_W'(sbws_pkg::MAX_WORDS_DEF);
  endfunction

  function automatic sbws_pkg::event_t pin_event(input logic kind,
                                       input logic [sbws_pkg::SAMPLE_W-1:0] s,
                                       input logic ck, input logic mi, input logic mo,
                                       input logic cs, input logic ce, input logic se);
    sbws_pkg::event_t ev;
    ev.kind         = kind;
    ev.sample_index = s;
    ev.clk_level    = ck;
    ev.miso_level   = mi;
    ev.mosi_level   = mo;
    ev.cs_level     = cs;
    ev.clk_edge     = ce;
    ev.cs_edge      = se;
    return ev;
  endfunction

  function automatic sbws_pkg::result_t select_result(input logic [1:0] old_lvl,
                                                      input logic new_lvl);
    sbws_pkg::result_t r;
    r             = '0;
    r.result_kind = sbws_pkg::RES_SELECT;
    r.last        = 1'b1;
    r.cs_old      = old_lvl;
    r.cs_new      = new_lvl;
    return r;
  endfunction

  // Decoder prediction: updates the mirrored state and returns the results of one pin event.
  task sniff_pin_event(input sbws_pkg::event_t ev, output sbws_pkg::result_t res[2],
                       output int n);
    logic              active;
    logic [6:0]        size;
    logic [5:0]        pos;
    sbws_pkg::result_t r;
    n    = 0;
    size = eff_size(mirror_cfg.word_bits);
    res[0] = '0;
    res[1] = '0;
    if (ev.kind == sbws_pkg::EV_INITIAL) begin
      r             = '0;
      r.result_kind = sbws_pkg::RES_SELECT;
      r.cs_old      = sbws_pkg::CS_UNKNOWN;
      if (mirror_cfg.select_present) begin
        r.cs_new = ev.cs_level;
        if (mirror_cfg.select_active_high ? ev.cs_level : ~ev.cs_level) begin
          p_xfer_open  = 1'b1;
          p_xfer_start = ev.sample_index;
          p_mosi_seen  = '0;
          p_miso_seen  = '0;
        end
      end else begin
        r.cs_new = 1'b1;
      end
      res[n++] = r;
    end else begin
      active = mirror_cfg.select_present ?
               (mirror_cfg.select_active_high ? ev.cs_level : ~ev.cs_level) : 1'b1;

      // Select edge: report it, open or close the transfer and drop any partial word.
      if (mirror_cfg.select_present && ev.cs_edge) begin
        res[n++] = select_result({1'b0, ~ev.cs_level}, ev.cs_level);
        res[0].last = 1'b0;
        if (active) begin
          p_xfer_open  = 1'b1;
          p_xfer_start = ev.sample_index;
          p_mosi_seen  = '0;
          p_miso_seen  = '0;
        end else if (p_xfer_open) begin
          r              = '0;
          r.result_kind  = sbws_pkg::RES_END;
          r.first_sample = p_xfer_start;
          r.end_sample   = ev.sample_index;
          r.mosi_count   = mirror_cfg.mosi_present ? p_mosi_seen : '0;
          r.miso_count   = mirror_cfg.miso_present ? p_miso_seen : '0;
          res[n++] = r;
        end
        p_bit_cnt = '0;
        p_mosi_sh = '0;
        p_miso_sh = '0;
      end

      // Shift on the sampling clock edge; the first clock edge seen while active is only a reference.
      if (active && ev.clk_edge) begin
        if (p_skip_edge) begin
          p_skip_edge = 1'b0;
        end else if (ev.clk_level == (mirror_cfg.clock_polarity == mirror_cfg.clock_phase)) begin
          if (p_bit_cnt == 7'd0) p_word_first = ev.sample_index;
          pos = p_bit_cnt[5:0];
          if (mirror_cfg.mosi_present) begin
            if (!mirror_cfg.lsb_first)
              p_mosi_sh = {p_mosi_sh[sbws_pkg::WORD_W-2:0], ev.mosi_level};
            else if (!p_bit_cnt[6]) p_mosi_sh[pos] = p_mosi_sh[pos] | ev.mosi_level;
          end
          if (mirror_cfg.miso_present) begin
            if (!mirror_cfg.lsb_first)
              p_miso_sh = {p_miso_sh[sbws_pkg::WORD_W-2:0], ev.miso_level};
            else if (!p_bit_cnt[6]) p_miso_sh[pos] = p_miso_sh[pos] | ev.miso_level;
          end
          p_bit_cnt = p_bit_cnt + 7'd1;
          if (p_bit_cnt == size) begin
            r              = '0;
            r.result_kind  = sbws_pkg::RES_WORD;
            r.mosi_word    = mirror_cfg.mosi_present ? p_mosi_sh : '0;
            r.miso_word    = mirror_cfg.miso_present ? p_miso_sh : '0;
            r.first_sample = p_word_first;
            r.end_sample   = ev.sample_index;
            res[n++] = r;
            if (mirror_cfg.miso_present) p_miso_seen = bump_count(p_miso_seen);
            if (mirror_cfg.mosi_present) p_mosi_seen = bump_count(p_mosi_seen);
            p_bit_cnt = '0;
            p_mosi_sh = '0;
            p_miso_sh = '0;
          end
        end
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
  endtask

  task note_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
    end
  endtask

  // Scoreboard: predicts on each accepted event, checks each result transaction in order.
  always @(posedge clk) begin
    sbws_pkg::event_t  ev;
    sbws_pkg::result_t got;
    sbws_pkg::result_t want;
    sbws_pkg::result_t fresh[2];
    int                n;
    if (!rst_n) begin
      mirror_cfg   = '{clock_polarity: 1'b0, clock_phase: 1'b0, lsb_first: 1'b0,
                       select_active_high: 1'b0, word_bits: sbws_pkg::WORD_BITS_DEF,
                       miso_present: 1'b1, mosi_present: 1'b1, select_present: 1'b1};
      p_bit_cnt    = '0;
      p_mosi_sh    = '0;
      p_miso_sh    = '0;
      p_word_first = '0;
      p_skip_edge  = 1'b1;
      p_xfer_open  = 1'b0;
      p_xfer_start = '0;
      p_mosi_seen  = '0;
      p_miso_seen  = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.result_kind  = out_tuser;
        got.last         = out_tlast;
        got.cs_old       = out_tdata[1:0];
        got.cs_new       = out_tdata[2];
        got.mosi_word    = out_tdata[66:3];
        got.miso_word    = out_tdata[130:67];
        got.first_sample = out_tdata[178:131];
        got.end_sample   = out_tdata[226:179];
        got.mosi_count   = out_tdata[235:227];
        got.miso_count   = out_tdata[244:236];
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result expected none actual kind %0d data %0h",
                   $time, got.result_kind, out_tdata);
        end else begin
          want = pending_results.pop_front();
          note_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
          note_field("last", 64'(want.last), 64'(got.last));
          note_field("cs_old", 64'(want.cs_old), 64'(got.cs_old));
          note_field("cs_new", 64'(want.cs_new), 64'(got.cs_new));
          note_field("mosi_word", want.mosi_word, got.mosi_word);
          note_field("miso_word", want.miso_word, got.miso_word);
          note_field("first_sample", 64'(want.first_sample), 64'(got.first_sample));
          note_field("end_sample", 64'(want.end_sample), 64'(got.end_sample));
          note_field("mosi_count", 64'(want.mosi_count), 64'(got.mosi_count));
          note_field("miso_count", 64'(want.miso_count), 64'(got.miso_count));
          note_field("tdata padding", 64'(0),
                     64'(out_tdata[sbws_pkg::OUT_TDATA_W-1:245]));
        end
      end

      if (in_tvalid && in_tready) begin
        ev.kind         = in_tuser;
        ev.sample_index = in_tdata[47:0];
        ev.clk_level    = in_tdata[48];
        ev.miso_level   = in_tdata[49];
        ev.mosi_level   = in_tdata[50];
        ev.cs_level     = in_tdata[51];
        ev.clk_edge     = in_tdata[52];
        ev.cs_edge      = in_tdata[53];
        sniff_pin_event(ev, fresh, n);
        if (row_typed) begin
          pending_results.push_back(row_want);
        end else begin
          for (int k = 0; k < n; k++) pending_results.push_back(fresh[k]);
        end
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sbws_pkg::REG_CPOL:       mirror_cfg.clock_polarity     = cfg_data[0];
          sbws_pkg::REG_CPHA:       mirror_cfg.clock_phase        = cfg_data[0];
          sbws_pkg::REG_LSB_FIRST:  mirror_cfg.lsb_first          = cfg_data[0];
          sbws_pkg::REG_SEL_ACT_HI: mirror_cfg.select_active_high = cfg_data[0];
          sbws_pkg::REG_WORD_BITS:
            mirror_cfg.word_bits = cfg_data[sbws_pkg::WBITS_W-1:0];
          sbws_pkg::REG_MISO_PRES:  mirror_cfg.miso_present       = cfg_data[0];
          sbws_pkg::REG_MOSI_PRES:  mirror_cfg.mosi_present       = cfg_data[0];
          sbws_pkg::REG_SEL_PRES:   mirror_cfg.select_present     = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off that lets the block back up.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one pin event and wait for its transaction.
  task send_event(input sbws_pkg::event_t ev, input bit typed, input sbws_pkg::result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.kind;
    in_tdata  <= {2'b00, ev.cs_edge, ev.clk_edge, ev.cs_level, ev.mosi_level,
                  ev.miso_level, ev.clk_level, ev.sample_index};
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every expected result is out and the block has settled.
  task wait_idle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Load all eight registers, keeping the write channel busy throughout.
  task program_regs(input sbws_pkg::cfg_t c);
    logic [sbws_pkg::CFG_IDX_W-1:0]  idx[8];
    logic [sbws_pkg::CFG_DATA_W-1:0] val[8];
    idx = '{sbws_pkg::REG_CPOL, sbws_pkg::REG_CPHA, sbws_pkg::REG_LSB_FIRST,
            sbws_pkg::REG_SEL_ACT_HI, sbws_pkg::REG_WORD_BITS, sbws_pkg::REG_MISO_PRES,
            sbws_pkg::REG_MOSI_PRES, sbws_pkg::REG_SEL_PRES};
    val = '{sbws_pkg::CFG_DATA_W'(c.clock_polarity), sbws_pkg::CFG_DATA_W'(c.clock_phase),
            sbws_pkg::CFG_DATA_W'(c.lsb_first), sbws_pkg::CFG_DATA_W'(c.select_active_high),
            sbws_pkg::CFG_DATA_W'(c.word_bits), sbws_pkg::CFG_DATA_W'(c.miso_present),
            sbws_pkg::CFG_DATA_W'(c.mosi_present), sbws_pkg::CFG_DATA_W'(c.select_present)};
    for (int k = 0; k < 8; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // One SPI transfer: optional select assertion, clock edges with random data, deassertion.
  // It is abandoned mid-word when the phase budget runs out, unless it is the saturation run.
  task stream_transfer(input int edges, input bit with_assert, input int target, input bit sat);
    sbws_pkg::event_t ev;
    logic   assert_lvl;
    logic   samp_lvl;
    assert_lvl = cur_cfg.select_active_high;
    samp_lvl   = (cur_cfg.clock_polarity == cur_cfg.clock_phase);
    if (with_assert) begin
      if ($urandom_range(4) == 0) cap_sample = sbws_pkg::SAMPLE_W'({$urandom, $urandom});
      pin_cs = assert_lvl;
      ev = pin_event(EV_EDGE, cap_sample, pin_clk, $urandom_range(1), $urandom_range(1),
                     pin_cs, 1'b0, 1'b1);
      if ($urandom_range(4) == 0) begin
        pin_clk      = ~pin_clk;
        ev.clk_level = pin_clk;
        ev.clk_edge  = 1'b1;
      end
      send_event(ev, 1'b0, '0);
    end
    for (int i = 0; i < edges; i++) begin
      if (!sat && items_sent >= target) return;
      cap_sample = cap_sample + sbws_pkg::SAMPLE_W'($urandom_range(1, 50));
      ev = pin_event(EV_EDGE, cap_sample, pin_clk, $urandom_range(1), $urandom_range(1),
                     pin_cs, 1'b1, 1'b0);
      if (sat) begin
        pin_clk = samp_lvl;
      end else if ($urandom_range(9) == 0) begin
        ev.clk_edge = 1'b0;
      end else begin
        pin_clk = ~pin_clk;
      end
      ev.clk_level = pin_clk;
      send_event(ev, 1'b0, '0);
    end
    pin_cs = ~assert_lvl;
    for (int rep = 0; rep < (($urandom_range(9) == 0) ? 2 : 1); rep++) begin
      cap_sample = cap_sample + sbws_pkg::SAMPLE_W'($urandom_range(1, 50));
      ev = pin_event(EV_EDGE, cap_sample, pin_clk, $urandom_range(1), $urandom_range(1),
                     pin_cs, 1'b0, 1'b1);
      if ($urandom_range(4) == 0) begin
        pin_clk      = ~pin_clk;
        ev.clk_level = pin_clk;
        ev.clk_edge  = 1'b1;
      end
      send_event(ev, 1'b0, '0);
    end
  endtask

  // Random phase: mostly well-formed transfers, some raw noise and initial-state events.
  task run_phase(input phase_plan_t p);
    sbws_pkg::event_t ev;
    int     target;
    int     pick;
    int     size;
    bit     sat_done;
    program_regs(p.c);
    send_idle = p.send_idle;
    stall_pct = p.recv_stall;
    hold_req  = p.pressure;
    target    = items_sent + p.n_items;
    sat_done  = !p.saturate;
    size      = eff_size(p.c.word_bits);
    // Sometimes carry on clocking the word left over from the previous settings.
    if ($urandom_range(1) == 1) stream_transfer($urandom_range(1, 2 * size + 2), 1'b0, target, 1'b0);
    while (items_sent < target || !sat_done) begin
      pick = $urandom_range(99);
      if (!sat_done) begin
        stream_transfer(SAT_EDGES, 1'b1, target, 1'b1);
        sat_done = 1'b1;
      end else if (pick < 84) begin
        stream_transfer($urandom_range(1, 4 * size + 3), 1'b1, target, 1'b0);
      end else begin
        ev = pin_event((pick < 96) ? EV_EDGE : sbws_pkg::EV_INITIAL,
                       sbws_pkg::SAMPLE_W'({$urandom, $urandom}),
                       $urandom_range(1), $urandom_range(1), $urandom_range(1),
                       $urandom_range(1), $urandom_range(1), $urandom_range(1));
        pin_clk = ev.clk_level;
        pin_cs  = ev.cs_level;
        send_event(ev, 1'b0, '0);
      end
    end
    wait_idle();
  endtask

  // Main sequence.
  initial begin
    sbws_pkg::result_t w;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_cfg   = '{clock_polarity: 1'b0, clock_phase: 1'b0, lsb_first: 1'b0,
                  select_active_high: 1'b0, word_bits: sbws_pkg::WORD_BITS_DEF,
                  miso_present: 1'b1, mosi_present: 1'b1, select_present: 1'b1};

    // Directed table, run at reset settings: active-low select, rising-edge sampling, MSB first.
    // Initial state with deasserted select; the edge flags must be ignored.
    dir_rows.push_back('{pin_event(sbws_pkg::EV_INITIAL, '0, 1, 1, 1, 1, 1, 1), 1'b1,
                         select_result(sbws_pkg::CS_UNKNOWN, 1'b1)});
    // Deassertion with no transfer ever opened gives no transfer end.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h5, 0, 0, 0, 1, 0, 1), 1'b1,
                         select_result(2'd0, 1'b1)});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h10, 0, 0, 0, 0, 0, 1), 1'b1,
                         select_result(2'd1, 1'b0)});
    // First clock edge is skipped, then a falling edge that does not sample.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h11, 1, 1, 1, 0, 1, 0), 1'b0, '0});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h12, 0, 1, 1, 0, 1, 0), 1'b0, '0});
    // Eight sampling edges: MOSI all ones, MISO all zeros, ending on the largest sample index.
    for (int k = 0; k < 7; k++)
      dir_rows.push_back('{pin_event(EV_EDGE, 48'h20 + 48'(2 * k), 1, 0, 1, 0, 1, 0), 1'b0, '0});
    w = '0;
    w.result_kind  = sbws_pkg::RES_WORD;
    w.last         = 1'b1;
    w.mosi_word    = 64'hFF;
    w.first_sample = 48'h20;
    w.end_sample   = 48'hFFFF_FFFF_FFFF;
    dir_rows.push_back('{pin_event(EV_EDGE, 48'hFFFF_FFFF_FFFF, 1, 0, 1, 0, 1, 0), 1'b1, w});
    // Deassertion with a clock edge, then a repeated deassertion that repeats the counts.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h0, 0, 1, 0, 1, 1, 1), 1'b0, '0});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h3, 0, 0, 0, 1, 0, 1), 1'b0, '0});
    // Clock edge while deselected is ignored.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h4, 1, 1, 1, 1, 1, 0), 1'b0, '0});
    // Initial state with select asserted opens a transfer.
    dir_rows.push_back('{pin_event(sbws_pkg::EV_INITIAL, 48'h40, 0, 0, 0, 0, 0, 0), 1'b1,
                         select_result(sbws_pkg::CS_UNKNOWN, 1'b0)});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h41, 1, 1, 0, 0, 1, 0), 1'b0, '0});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h42, 1, 1, 1, 0, 1, 0), 1'b0, '0});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h43, 1, 0, 0, 0, 1, 0), 1'b0, '0});
    // Select edge mid-word clears the partial word, then the same event shifts a bit.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h44, 1, 1, 1, 0, 1, 1), 1'b0, '0});
    // Event with no edge flags gives nothing; then a deassertion with zero counts.
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h45, 1, 1, 1, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{pin_event(EV_EDGE, 48'h46, 0, 0, 0, 1, 0, 1), 1'b0, '0});

    // Random phases: settings, sender idling, receiver stalling, items, saturation, hold-off.
    plans[0]  = '{'{1'b0, 1'b0, 1'b0, 1'b0, 7'd8,   1'b1, 1'b1, 1'b1},  0,  0, 120, 1'b0, 1'b0};
    plans[1]  = '{'{1'b0, 1'b1, 1'b1, 1'b0, 7'd5,   1'b1, 1'b1, 1'b1}, 49,  0, 120, 1'b0, 1'b0};
    plans[2]  = '{'{1'b1, 1'b0, 1'b0, 1'b1, 7'd16,  1'b1, 1'b1, 1'b1},  0, 49, 120, 1'b0, 1'b0};
    plans[3]  = '{'{1'b1, 1'b1, 1'b1, 1'b1, 7'd1,   1'b1, 1'b1, 1'b1},  9,  9, 110, 1'b1, 1'b0};
    plans[4]  = '{'{1'b0, 1'b0, 1'b1, 1'b0, 7'd64,  1'b1, 1'b0, 1'b1},  0,  0, 180, 1'b0, 1'b1};
    plans[5]  = '{'{1'b1, 1'b0, 1'b1, 1'b0, 7'd0,   1'b0, 1'b1, 1'b1}, 49,  0, 110, 1'b0, 1'b0};
    plans[6]  = '{'{1'b0, 1'b1, 1'b0, 1'b1, 7'd127, 1'b1, 1'b1, 1'b0},  0, 49, 110, 1'b0, 1'b0};
    plans[7]  = '{'{1'b1, 1'b1, 1'b1, 1'b0, 7'd3,   1'b0, 1'b0, 1'b1},  9,  9, 110, 1'b0, 1'b0};
    plans[8]  = '{'{1'b0, 1'b0, 1'b0, 1'b1, 7'd64,  1'b1, 1'b1, 1'b1},  0,  0, 130, 1'b0, 1'b0};
    plans[9]  = '{'{1'b1, 1'b0, 1'b1, 1'b1, 7'd12,  1'b1, 1'b1, 1'b0}, 49,  0, 110, 1'b0, 1'b0};
    plans[10] = '{'{1'b0, 1'b1, 1'b1, 1'b0, 7'd7,   1'b1, 1'b1, 1'b1},  0, 49, 110, 1'b0, 1'b0};
    plans[11] = '{'{1'b1, 1'b1, 1'b0, 1'b0, 7'd2,   1'b1, 1'b1, 1'b1},  9,  9, 110, 1'b0, 1'b0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
    wait_idle();

    foreach (plans[i]) run_phase(plans[i]);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_spi_bus_word_sniffer_unit OK");
    end else begin
      $display("tb_spi_bus_word_sniffer_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbws_pkg.sv
rtl/sbws_core.sv
rtl/sbws_out.sv
rtl/spi_bus_word_sniffer_unit.sv
sim/tb_spi_bus_word_sniffer_unit.sv
